@@ src/ssfl_pkg.sv @@
// Shared types and constants for the substring search block.
// No dependencies; ssfl_front, ssfl_back and substring_search_first_last use this package.
`default_nettype none

package ssfl_pkg;

    localparam int PATTERN_MAX_DEF = 16;
    localparam int OFFSET_BITS_DEF = 32;
    localparam int PAT_BYTES       = 16;
    localparam int CFG_DATA_BITS   = 64;
    localparam int CFG_INDEX_BITS  = 2;
    localparam int RESULT_OFF_BITS = 32;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_PATTERN_LENGTH = 2'd0,
        CFG_FIND_LAST      = 2'd1,
        CFG_PATTERN_LOW    = 2'd2,
        CFG_PATTERN_HIGH   = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       is_last;
        logic       is_empty;
    } t_in;

    typedef struct packed {
        logic                       found;
        logic [RESULT_OFF_BITS-1:0] match_offset;
        logic                       length_overflow;
    } t_out;

    typedef struct packed {
        logic [4:0]               pattern_length;
        logic                     find_last;
        logic [CFG_DATA_BITS-1:0] pattern_low;
        logic [CFG_DATA_BITS-1:0] pattern_high;
    } t_cfg;

    // Control part of one classified beat handed from front to back.
    typedef struct packed {
        logic hit;
        logic is_last;
        logic overflow;
    } t_rec_ctl;

    localparam int REC_CTL_BITS = $bits(t_rec_ctl);

endpackage

`default_nettype wire

@@ src/ssfl_fifo.sv @@
// Two-entry register queue between the front and back parts.
// Depends on nothing but its WIDTH parameter.
`default_nettype none

module ssfl_fifo #(
    parameter int WIDTH = 8
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    input  wire logic             i_pop,
    output logic      [WIDTH-1:0] o_data,
    output logic                  o_full,
    output logic                  o_empty
);

    logic [1:0][WIDTH-1:0] r_mem;
    logic                  r_wr_ptr;
    logic                  r_rd_ptr;
    logic [1:0]            r_count;
    logic                  do_push;
    logic                  do_pop;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (do_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 2'd1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

@@ src/ssfl_front.sv @@
// Front part: takes text beats, shifts the byte window, compares it with the
// pattern and counts bytes. Emits one classified record per useful beat. Uses ssfl_pkg.
`default_nettype none

module ssfl_front #(
    parameter int PATTERN_MAX = 16,
    parameter int OFFSET_BITS = 32
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_valid,
    input  wire ssfl_pkg::t_in               i_item,
    output logic                             o_stall,
    input  wire ssfl_pkg::t_cfg              i_cfg,
    input  wire logic                        i_full,
    output logic                             o_push,
    output ssfl_pkg::t_rec_ctl               o_rec_ctl,
    output logic [OFFSET_BITS-1:0]           o_rec_value
);

    import ssfl_pkg::*;

    localparam int LEN_BITS = $clog2(PATTERN_MAX + 1);

    logic [PATTERN_MAX-1:0][7:0] r_window;
    logic [PATTERN_MAX-1:0][7:0] n_window;
    logic [OFFSET_BITS-1:0]      r_count;
    logic [OFFSET_BITS-1:0]      n_count;
    logic                        r_ovf;
    logic                        n_ovf;

    logic [PAT_BYTES-1:0][7:0]   pat;
    logic [LEN_BITS-1:0]         eff_len;
    logic                        accept;
    logic                        take;
    logic                        at_max;
    logic                        win_ok;
    logic [OFFSET_BITS-1:0]      count_inc;
    logic                        hit;

    assign pat     = {i_cfg.pattern_high, i_cfg.pattern_low};
    assign o_stall = i_full;
    assign accept  = i_valid && !i_full;
    assign take    = accept && !i_item.is_empty;
    assign at_max  = (r_count == {OFFSET_BITS{1'b1}});
    assign count_inc = r_count + OFFSET_BITS'(1);

    always_comb begin
        if (int'(i_cfg.pattern_length) > PATTERN_MAX) begin
            eff_len = LEN_BITS'(PATTERN_MAX);
        end else begin
            eff_len = LEN_BITS'(i_cfg.pattern_length);
        end
    end

    // Newest byte enters at entry 0.
    always_comb begin
        n_window    = r_window;
        n_window[0] = i_item.text_byte;
        for (int j = 1; j < PATTERN_MAX; j++) begin
            n_window[j] = r_window[j-1];
        end
    end

    // Window entry j holds text byte that pattern byte eff_len-1-j must match.
    always_comb begin
        logic [LEN_BITS-1:0] k;
        logic [7:0]          pb;
        win_ok = 1'b1;
        for (int j = 0; j < PATTERN_MAX; j++) begin
            k  = eff_len - LEN_BITS'(j + 1);
            pb = 8'h00;
            if (int'(k) < PAT_BYTES) begin
                pb = pat[4'(k)];
            end
            if ((j < int'(eff_len)) && (n_window[j] != pb)) begin
                win_ok = 1'b0;
            end
        end
    end

    always_comb begin
        n_count = r_count;
        n_ovf   = r_ovf;
        hit     = 1'b0;
        if (take) begin
            if (r_ovf || at_max) begin
                n_ovf = 1'b1;
            end else begin
                n_count = count_inc;
                hit = (eff_len != '0) && (count_inc >= OFFSET_BITS'(eff_len)) && win_ok;
            end
        end
        o_push              = accept && (!i_item.is_empty || i_item.is_last);
        o_rec_ctl.hit       = hit;
        o_rec_ctl.is_last   = i_item.is_last;
        o_rec_ctl.overflow  = n_ovf;
        o_rec_value         = hit ? (count_inc - OFFSET_BITS'(eff_len)) : n_count;
        // Start the next text clean.
        if (accept && i_item.is_last) begin
            n_count = '0;
            n_ovf   = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_ovf   <= 1'b0;
        end else begin
            r_count <= n_count;
            r_ovf   <= n_ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_window <= n_window;
        end
    end

endmodule

`default_nettype wire

@@ src/ssfl_back.sv @@
// Back part: drains classified records, keeps the chosen match and builds the
// result beat in an output register. Uses ssfl_pkg.
`default_nettype none

module ssfl_back #(
    parameter int OFFSET_BITS = 32
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire ssfl_pkg::t_cfg              i_cfg,
    input  wire logic                        i_empty,
    input  wire ssfl_pkg::t_rec_ctl          i_rec_ctl,
    input  wire logic [OFFSET_BITS-1:0]      i_rec_value,
    output logic                             o_pop,
    output logic                             o_valid,
    output ssfl_pkg::t_out                   o_item,
    input  wire logic                        i_stall
);

    import ssfl_pkg::*;

    localparam int WIDE_BITS = (OFFSET_BITS > RESULT_OFF_BITS) ? OFFSET_BITS : RESULT_OFF_BITS;

    logic                   r_match_seen;
    logic                   n_match_seen;
    logic [OFFSET_BITS-1:0] r_held_offset;
    logic [OFFSET_BITS-1:0] n_held_offset;
    logic                   r_out_valid;
    t_out                   r_out;
    t_out                   n_out;
    logic                   out_free;
    logic                   load;
    logic [OFFSET_BITS-1:0] off_sel;
    logic [WIDE_BITS-1:0]   wide_off;

    assign out_free = !r_out_valid || !i_stall;
    assign o_pop    = !i_empty && (!i_rec_ctl.is_last || out_free);
    assign load     = o_pop && i_rec_ctl.is_last;
    assign o_valid  = r_out_valid;
    assign o_item   = r_out;

    always_comb begin
        n_match_seen  = r_match_seen;
        n_held_offset = r_held_offset;
        if (o_pop && i_rec_ctl.hit && (!r_match_seen || i_cfg.find_last)) begin
            n_match_seen  = 1'b1;
            n_held_offset = i_rec_value;
        end

        if (i_cfg.pattern_length == 5'd0) begin
            off_sel = i_cfg.find_last ? i_rec_value : '0;
        end else begin
            off_sel = n_match_seen ? n_held_offset : '0;
        end
        wide_off = WIDE_BITS'(off_sel);

        n_out.found           = (i_cfg.pattern_length == 5'd0) || n_match_seen;
        n_out.match_offset    = wide_off[RESULT_OFF_BITS-1:0];
        n_out.length_overflow = i_rec_ctl.overflow;

        // Drop match state once the text has ended.
        if (load) begin
            n_match_seen  = 1'b0;
            n_held_offset = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_match_seen  <= 1'b0;
            r_held_offset <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_match_seen  <= n_match_seen;
            r_held_offset <= n_held_offset;
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (out_free) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out <= n_out;
        end
    end

endmodule

`default_nettype wire

@@ src/substring_search_first_last.sv @@
// Substring search, first or last match. One text beat per cycle sustained while
// o_in_stall is low; it rises when the two-entry queue ahead of the back part is
// full. The window compare in the front part is combinational; the record of the
// last beat passes the queue register, then the back part's output register.
// Reset (synchronous, active low) clears configuration, counters, queue and output.
// Uses ssfl_pkg, ssfl_front, ssfl_fifo, ssfl_back.
`default_nettype none

module substring_search_first_last #(
    parameter int PATTERN_MAX = ssfl_pkg::PATTERN_MAX_DEF,
    parameter int OFFSET_BITS = ssfl_pkg::OFFSET_BITS_DEF
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_in_valid,
    input  wire ssfl_pkg::t_in                         i_in,
    output logic                                       o_in_stall,
    output logic                                       o_out_valid,
    output ssfl_pkg::t_out                             o_out,
    input  wire logic                                  i_out_stall,
    input  wire logic                                  i_cfg_we,
    input  wire logic [ssfl_pkg::CFG_INDEX_BITS-1:0]   i_cfg_index,
    input  wire logic [ssfl_pkg::CFG_DATA_BITS-1:0]    i_cfg_data
);

    import ssfl_pkg::*;

    localparam int REC_BITS = REC_CTL_BITS + OFFSET_BITS;

    t_cfg                   r_cfg;
    t_rec_ctl               push_ctl;
    logic [OFFSET_BITS-1:0] push_value;
    logic                   push;
    t_rec_ctl               pop_ctl;
    logic [OFFSET_BITS-1:0] pop_value;
    logic [REC_BITS-1:0]    fifo_out;
    logic                   pop;
    logic                   full;
    logic                   empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_PATTERN_LENGTH: r_cfg.pattern_length <= i_cfg_data[4:0];
                CFG_FIND_LAST:      r_cfg.find_last      <= i_cfg_data[0];
                CFG_PATTERN_LOW:    r_cfg.pattern_low    <= i_cfg_data;
                CFG_PATTERN_HIGH:   r_cfg.pattern_high   <= i_cfg_data;
                default:            r_cfg                <= r_cfg;
            endcase
        end
    end

    ssfl_front #(
        .PATTERN_MAX (PATTERN_MAX),
        .OFFSET_BITS (OFFSET_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_in_valid),
        .i_item      (i_in),
        .o_stall     (o_in_stall),
        .i_cfg       (r_cfg),
        .i_full      (full),
        .o_push      (push),
        .o_rec_ctl   (push_ctl),
        .o_rec_value (push_value)
    );

    ssfl_fifo #(
        .WIDTH (REC_BITS)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  ({push_ctl, push_value}),
        .i_pop   (pop),
        .o_data  (fifo_out),
        .o_full  (full),
        .o_empty (empty)
    );

    assign pop_ctl   = t_rec_ctl'(fifo_out[REC_BITS-1:OFFSET_BITS]);
    assign pop_value = fifo_out[OFFSET_BITS-1:0];

    ssfl_back #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_empty     (empty),
        .i_rec_ctl   (pop_ctl),
        .i_rec_value (pop_value),
        .o_pop       (pop),
        .o_valid     (o_out_valid),
        .o_item      (o_out),
        .i_stall     (i_out_stall)
    );

endmodule

`default_nettype wire
